FILE: src/sha256_pkg.sv
// Package with SHA-256 constants, round functions and sequencer state type.
package sha256_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 61;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;
  localparam int unsigned DigestWords = 8;
  localparam logic [ByteW-1:0] PadByte = 8'h80;
  localparam int unsigned LenOffset = 56;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t initial_h(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85; 3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a; 3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

FILE: src/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher with one shared round unit and a 16-word schedule window.
// A byte that does not fill a block is taken in the idle state; a block-filling byte is followed
// by the load, round and add states; the end item pads one byte per cycle, compresses one or two
// blocks, then presents eight digest items, one per cycle while tready is high.
// Input is held off by the single round unit: s_tready is low while a 64-byte block is compressed.
// Synchronous reset restores the initial hash values and a zero byte count.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // data_byte[7:0]
  input  logic        s_tuser,  // byte_present
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_tlast
);
  import sha256_pkg::*;

  state_t state;
  word_t chain [DigestWords];
  word_t v [DigestWords];
  word_t w [16];
  logic [CountW-1:0] count;
  logic [CountW+2:0] bit_len;
  logic pad_started;
  logic len_ok;
  logic len_done;
  logic [5:0] round;
  logic [2:0] out_idx;
  logic closing;

  logic [5:0] fill;
  logic [2:0] len_sel;
  logic [ByteW-1:0] pad_byte;
  word_t w_new, t1, t2, s0, s1;

  assign fill = count[5:0];
  assign len_sel = ~fill[2:0];
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {5'd0, out_idx, chain[out_idx]};
  assign m_tlast = (out_idx == 3'd7);

  always_comb begin
    if (!pad_started) pad_byte = PadByte;
    else if (len_ok && fill >= 6'(LenOffset)) pad_byte = bit_len[{len_sel, 3'b000} +: ByteW];
    else pad_byte = '0;
  end

  always_comb begin
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
         ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round) + w[0];
    t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      closing <= 1'b0;
      pad_started <= 1'b0;
      len_ok <= 1'b0;
      len_done <= 1'b0;
      round <= '0;
      out_idx <= '0;
      for (int i = 0; i < DigestWords; i++) chain[i] <= initial_h(3'(i));
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            closing <= s_tlast;
            bit_len <= {count + CountW'(s_tuser), 3'b000};
            pad_started <= 1'b0;
            len_ok <= 1'b0;
            len_done <= 1'b0;
            if (s_tuser) begin
              for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i+1][31:24]};
              w[15] <= {w[15][23:0], s_tdata};
              count <= count + CountW'(1);
              if (fill == 6'd63) state <= ST_LOAD;
              else if (s_tlast) state <= ST_PAD;
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i+1][31:24]};
          w[15] <= {w[15][23:0], pad_byte};
          if (!pad_started) begin
            pad_started <= 1'b1;
            len_ok <= (fill < 6'(LenOffset));
          end
          count <= count + CountW'(1);
          if (fill == 6'd63) begin
            state <= ST_LOAD;
            if (pad_started && len_ok) len_done <= 1'b1;
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < DigestWords; i++) v[i] <= chain[i];
          round <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'(Rounds - 1)) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < DigestWords; i++) chain[i] <= chain[i] + v[i];
          if (!closing) begin
            state <= ST_IDLE;
          end else if (len_done) begin
            out_idx <= '0;
            state <= ST_OUT;
          end else begin
            len_ok <= 1'b1;
            state <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < DigestWords; i++) chain[i] <= initial_h(3'(i));
              count <= '0;
              closing <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("digest item shown while taking input");
  a_last_wrap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(out_idx)) else $error("digest index moved");

endmodule
